FILE: rtl/segint_pkg.sv
// shared types and constants for the segment intersection block
package segint_pkg;

  localparam int IN_WIDTH        = 16;
  localparam int OUT_WIDTH       = 24;
  localparam int QUOT_BITS       = 24;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;

  typedef enum logic [1:0] {
    OUT_NONE      = 2'd0,
    OUT_POINT     = 2'd1,
    OUT_COLLINEAR = 2'd2
  } outcome_e;

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] ax;
    logic signed [IN_WIDTH-1:0] ay;
    logic signed [IN_WIDTH-1:0] bx;
    logic signed [IN_WIDTH-1:0] by_coord;
    logic signed [IN_WIDTH-1:0] cx;
    logic signed [IN_WIDTH-1:0] cy;
    logic signed [IN_WIDTH-1:0] dx;
    logic signed [IN_WIDTH-1:0] dy;
  } seg_in_t;

  typedef struct packed {
    outcome_e                    outcome;
    logic signed [OUT_WIDTH-1:0] point_x;
    logic signed [OUT_WIDTH-1:0] point_y;
  } seg_out_t;

  typedef struct packed {
    logic                        valid;
    outcome_e                    outcome;
    logic                        neg_x;
    logic                        neg_y;
    logic                        ovf_x;
    logic                        ovf_y;
    logic signed [OUT_WIDTH-1:0] fix_x;
    logic signed [OUT_WIDTH-1:0] fix_y;
  } segint_ctl_t;

endpackage

FILE: rtl/segint_front.sv
// line equations, side tests, numerators and divider setup over five stages
module segint_front import segint_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int AW          = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  seg_in_t       item_i,
  output segint_ctl_t   ctl_o,
  output logic [AW-1:0] d_o,
  output logic [AW-1:0] rx_o,
  output logic [AW-1:0] ry_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int LW   = CW + 1;
  localparam int PW   = 2 * CW;
  localparam int LCW  = 2 * CW + 1;
  localparam int SPW  = LW + CW;
  localparam int DPW  = 2 * LW;
  localparam int SW   = 2 * CW + 3;
  localparam int DETW = 2 * CW + 3;
  localparam int NPW  = LW + LCW;
  localparam int NUMW = 3 * CW + 3;
  localparam int MW   = CW + 2 + FRAC_BITS;
  localparam int EW   = MW + OUT_WIDTH;
  localparam logic signed [EW-1:0] MAXV = (EW'(1) <<< (OUT_WIDTH - 1)) - EW'(1);
  localparam logic signed [EW-1:0] MINV = -(EW'(1) <<< (OUT_WIDTH - 1));

  logic signed [CW-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  assign x1 = item_i.ax[CW-1:0];
  assign y1 = item_i.ay[CW-1:0];
  assign x2 = item_i.bx[CW-1:0];
  assign y2 = item_i.by_coord[CW-1:0];
  assign x3 = item_i.cx[CW-1:0];
  assign y3 = item_i.cy[CW-1:0];
  assign x4 = item_i.dx[CW-1:0];
  assign y4 = item_i.dy[CW-1:0];

  // stage 1
  logic v1_q;
  logic signed [CW-1:0] x1_q, y1_q, x2_q, y2_q, x3_q, y3_q, x4_q, y4_q;
  logic signed [LW-1:0] la1_q, lb1_q, la2_q, lb2_q;
  logic signed [PW-1:0] p21_q, p12_q, p43_q, p34_q;

  // stage 2
  logic v2_q;
  logic signed [LW-1:0]  la1b_q, lb1b_q, la2b_q, lb2b_q;
  logic signed [LCW-1:0] lc1_q, lc2_q;
  logic signed [SPW-1:0] m13_q, n13_q, m14_q, n14_q, m21_q, n21_q, m22_q, n22_q;
  logic signed [DPW-1:0] d1_q, d2_q;
  logic signed [CW:0]    sx_q, sy_q;

  // stage 3
  logic v3_q;
  logic signed [SW-1:0]   s1_q, s2_q, s3_q, s4_q;
  logic signed [DETW-1:0] det_q;
  logic signed [NPW-1:0]  u1_q, u2_q, w1_q, w2_q;
  logic signed [OUT_WIDTH-1:0] mx_q, my_q;

  // stage 4
  logic v4_q;
  outcome_e oc4_q;
  logic signed [NUMW-1:0] nx_q, ny_q;
  logic signed [DETW-1:0] det4_q;
  logic signed [OUT_WIDTH-1:0] fx4_q, fy4_q;

  // stage 5
  segint_ctl_t ctl_q;
  logic [AW-1:0] d_q, rx_q, ry_q;

  function automatic logic signed [OUT_WIDTH-1:0] mid_sat(input logic signed [CW:0] s);
    logic signed [MW-1:0] ms;
    logic signed [MW-1:0] half;
    logic signed [EW-1:0] ve;
    ms   = MW'(s) <<< FRAC_BITS;
    half = (ms + $signed(MW'({1'b0, ms[MW-1]}))) >>> 1;
    ve   = EW'(half);
    if (ve > MAXV) begin
      ve = MAXV;
    end else if (ve < MINV) begin
      ve = MINV;
    end
    return ve[OUT_WIDTH-1:0];
  endfunction

  function automatic logic touch(input logic signed [SW-1:0] p, input logic signed [SW-1:0] q);
    return (p == '0) || (q == '0) || (p[SW-1] != q[SW-1]);
  endfunction

  logic hit;
  assign hit = touch(s3_q, s4_q) && touch(s1_q, s2_q);

  logic [NUMW-1:0] nx_abs, ny_abs;
  logic [DETW-1:0] det_abs;
  logic [AW-1:0]   r0x, r0y, dmag;
  assign nx_abs  = nx_q[NUMW-1] ? NUMW'(-nx_q) : NUMW'(nx_q);
  assign ny_abs  = ny_q[NUMW-1] ? NUMW'(-ny_q) : NUMW'(ny_q);
  assign det_abs = det4_q[DETW-1] ? DETW'(-det4_q) : DETW'(det4_q);
  assign r0x     = AW'(nx_abs) << FRAC_BITS;
  assign r0y     = AW'(ny_abs) << FRAC_BITS;
  assign dmag    = AW'(det_abs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q  <= x1;
    y1_q  <= y1;
    x2_q  <= x2;
    y2_q  <= y2;
    x3_q  <= x3;
    y3_q  <= y3;
    x4_q  <= x4;
    y4_q  <= y4;
    la1_q <= LW'(y2) - LW'(y1);
    lb1_q <= LW'(x1) - LW'(x2);
    la2_q <= LW'(y4) - LW'(y3);
    lb2_q <= LW'(x3) - LW'(x4);
    p21_q <= PW'(x2) * PW'(y1);
    p12_q <= PW'(x1) * PW'(y2);
    p43_q <= PW'(x4) * PW'(y3);
    p34_q <= PW'(x3) * PW'(y4);

    la1b_q <= la1_q;
    lb1b_q <= lb1_q;
    la2b_q <= la2_q;
    lb2b_q <= lb2_q;
    lc1_q  <= LCW'(p21_q) - LCW'(p12_q);
    lc2_q  <= LCW'(p43_q) - LCW'(p34_q);
    m13_q  <= SPW'(la1_q) * SPW'(x3_q);
    n13_q  <= SPW'(lb1_q) * SPW'(y3_q);
    m14_q  <= SPW'(la1_q) * SPW'(x4_q);
    n14_q  <= SPW'(lb1_q) * SPW'(y4_q);
    m21_q  <= SPW'(la2_q) * SPW'(x1_q);
    n21_q  <= SPW'(lb2_q) * SPW'(y1_q);
    m22_q  <= SPW'(la2_q) * SPW'(x2_q);
    n22_q  <= SPW'(lb2_q) * SPW'(y2_q);
    d1_q   <= DPW'(la1_q) * DPW'(lb2_q);
    d2_q   <= DPW'(la2_q) * DPW'(lb1_q);
    sx_q   <= (CW+1)'(x1_q) + (CW+1)'(x2_q);
    sy_q   <= (CW+1)'(y1_q) + (CW+1)'(y2_q);

    s3_q  <= SW'(m13_q) + SW'(n13_q) + SW'(lc1_q);
    s4_q  <= SW'(m14_q) + SW'(n14_q) + SW'(lc1_q);
    s1_q  <= SW'(m21_q) + SW'(n21_q) + SW'(lc2_q);
    s2_q  <= SW'(m22_q) + SW'(n22_q) + SW'(lc2_q);
    det_q <= DETW'(d1_q) - DETW'(d2_q);
    u1_q  <= NPW'(lb1b_q) * NPW'(lc2_q);
    u2_q  <= NPW'(lb2b_q) * NPW'(lc1_q);
    w1_q  <= NPW'(la2b_q) * NPW'(lc1_q);
    w2_q  <= NPW'(la1b_q) * NPW'(lc2_q);
    mx_q  <= mid_sat(sx_q);
    my_q  <= mid_sat(sy_q);

    nx_q   <= NUMW'(u1_q) - NUMW'(u2_q);
    ny_q   <= NUMW'(w1_q) - NUMW'(w2_q);
    det4_q <= det_q;
    if (!hit) begin
      oc4_q <= OUT_NONE;
      fx4_q <= '0;
      fy4_q <= '0;
    end else if (det_q == '0) begin
      oc4_q <= OUT_COLLINEAR;
      fx4_q <= mx_q;
      fy4_q <= my_q;
    end else begin
      oc4_q <= OUT_POINT;
      fx4_q <= '0;
      fy4_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      d_q   <= '0;
      rx_q  <= '0;
      ry_q  <= '0;
    end else begin
      ctl_q.valid   <= v4_q;
      ctl_q.outcome <= oc4_q;
      ctl_q.neg_x   <= nx_q[NUMW-1] ^ det4_q[DETW-1];
      ctl_q.neg_y   <= ny_q[NUMW-1] ^ det4_q[DETW-1];
      ctl_q.ovf_x   <= {1'b0, r0x} >= ({1'b0, dmag} << QUOT_BITS);
      ctl_q.ovf_y   <= {1'b0, r0y} >= ({1'b0, dmag} << QUOT_BITS);
      ctl_q.fix_x   <= fx4_q;
      ctl_q.fix_y   <= fy4_q;
      d_q           <= dmag;
      rx_q          <= r0x;
      ry_q          <= r0y;
    end
  end

  assign ctl_o = ctl_q;
  assign d_o   = d_q;
  assign rx_o  = rx_q;
  assign ry_o  = ry_q;

endmodule

FILE: rtl/segint_div_cell.sv
// one restoring divider cell, resolves one quotient bit for both coordinates
module segint_div_cell import segint_pkg::*; #(
  parameter int AW  = 64,
  parameter int IDX = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  segint_ctl_t          ctl_i,
  input  logic [AW-1:0]        d_i,
  input  logic [AW-1:0]        rx_i,
  input  logic [AW-1:0]        ry_i,
  input  logic [QUOT_BITS-1:0] qx_i,
  input  logic [QUOT_BITS-1:0] qy_i,
  output segint_ctl_t          ctl_o,
  output logic [AW-1:0]        d_o,
  output logic [AW-1:0]        rx_o,
  output logic [AW-1:0]        ry_o,
  output logic [QUOT_BITS-1:0] qx_o,
  output logic [QUOT_BITS-1:0] qy_o
);

  logic [AW:0] dsh, tx, ty;
  logic [QUOT_BITS-1:0] qx_d, qy_d;
  logic [AW-1:0] rx_d, ry_d;

  segint_ctl_t ctl_q;
  logic [AW-1:0] d_q, rx_q, ry_q;
  logic [QUOT_BITS-1:0] qx_q, qy_q;

  always_comb begin
    dsh  = {1'b0, d_i} << IDX;
    tx   = {1'b0, rx_i} - dsh;
    ty   = {1'b0, ry_i} - dsh;
    qx_d = qx_i;
    qy_d = qy_i;
    qx_d[IDX] = ~tx[AW];
    qy_d[IDX] = ~ty[AW];
    rx_d = tx[AW] ? rx_i : tx[AW-1:0];
    ry_d = ty[AW] ? ry_i : ty[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      d_q   <= '0;
      rx_q  <= '0;
      ry_q  <= '0;
      qx_q  <= '0;
      qy_q  <= '0;
    end else begin
      ctl_q <= ctl_i;
      d_q   <= d_i;
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      qx_q  <= qx_d;
      qy_q  <= qy_d;
    end
  end

  assign ctl_o = ctl_q;
  assign d_o   = d_q;
  assign rx_o  = rx_q;
  assign ry_o  = ry_q;
  assign qx_o  = qx_q;
  assign qy_o  = qy_q;

endmodule

FILE: rtl/segment_intersection.sv
// Segment intersection pipeline. A new segment pair is taken in every clock cycle (busy
// stays low) and its result appears on result_o with strobe_o after the pipeline:
// five stages of multiply and add for the line equations, side tests and numerators,
// a chain of 24 divider cells that settle one quotient bit each, and one output stage
// for sign and saturation. The receiver cannot stall, so every result is shown once.
module segment_intersection import segint_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  seg_in_t  item_i,
  output logic     strobe_o,
  output seg_out_t result_o
);

  localparam int RW   = 3 * COORD_WIDTH + 3 + FRAC_BITS;
  localparam int DETW = 2 * COORD_WIDTH + 3;
  localparam int AW   = (RW > DETW + QUOT_BITS) ? RW : DETW + QUOT_BITS;
  localparam logic [QUOT_BITS-1:0] POS_LIM = {1'b0, {(QUOT_BITS-1){1'b1}}};
  localparam logic [QUOT_BITS-1:0] NEG_LIM = {1'b1, {(QUOT_BITS-1){1'b0}}};

  segint_ctl_t          ctl   [0:QUOT_BITS];
  logic [AW-1:0]        d_c   [0:QUOT_BITS];
  logic [AW-1:0]        rx_c  [0:QUOT_BITS];
  logic [AW-1:0]        ry_c  [0:QUOT_BITS];
  logic [QUOT_BITS-1:0] qx_c  [0:QUOT_BITS];
  logic [QUOT_BITS-1:0] qy_c  [0:QUOT_BITS];

  assign busy = 1'b0;

  segint_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .AW         (AW)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(start & ~busy),
    .item_i (item_i),
    .ctl_o  (ctl[0]),
    .d_o    (d_c[0]),
    .rx_o   (rx_c[0]),
    .ry_o   (ry_c[0])
  );

  assign qx_c[0] = '0;
  assign qy_c[0] = '0;

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_cell
    segint_div_cell #(
      .AW (AW),
      .IDX(QUOT_BITS - 1 - k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl[k]),
      .d_i   (d_c[k]),
      .rx_i  (rx_c[k]),
      .ry_i  (ry_c[k]),
      .qx_i  (qx_c[k]),
      .qy_i  (qy_c[k]),
      .ctl_o (ctl[k+1]),
      .d_o   (d_c[k+1]),
      .rx_o  (rx_c[k+1]),
      .ry_o  (ry_c[k+1]),
      .qx_o  (qx_c[k+1]),
      .qy_o  (qy_c[k+1])
    );
  end

  function automatic logic [OUT_WIDTH-1:0] finish(input logic [QUOT_BITS-1:0] q,
                                                  input logic neg, input logic ovf);
    logic [OUT_WIDTH-1:0] r;
    if (neg) begin
      r = (ovf || q > NEG_LIM) ? NEG_LIM : OUT_WIDTH'(~q + 1'b1);
    end else begin
      r = (ovf || q > POS_LIM) ? POS_LIM : OUT_WIDTH'(q);
    end
    return r;
  endfunction

  segint_ctl_t cl;
  assign cl = ctl[QUOT_BITS];

  logic     strobe_q;
  seg_out_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q.outcome <= cl.outcome;
    if (cl.outcome == OUT_POINT) begin
      result_q.point_x <= finish(qx_c[QUOT_BITS], cl.neg_x, cl.ovf_x);
      result_q.point_y <= finish(qy_c[QUOT_BITS], cl.neg_y, cl.ovf_y);
    end else begin
      result_q.point_x <= cl.fix_x;
      result_q.point_y <= cl.fix_y;
    end
  end

  assign strobe_o = strobe_q;
  assign result_o = result_q;

endmodule

FILE: rtl/segint_checker.sv
// port level checks for the segment intersection block, bound to the top level
module segint_checker import segint_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     strobe_o,
  input seg_out_t result_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised on a fully pipelined block");

  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (result_o.outcome == OUT_NONE || result_o.outcome == OUT_POINT ||
                  result_o.outcome == OUT_COLLINEAR))
    else $error("unknown outcome code on result transfer");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && result_o.outcome == OUT_NONE) |->
      (result_o.point_x == '0 && result_o.point_y == '0))
    else $error("nonzero point with no intersection");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(rst_ni) |-> !strobe_o)
    else $error("result transfer during reset");

endmodule

bind segment_intersection segint_checker u_segint_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .strobe_o(strobe_o),
  .result_o(result_o)
);

FILE: bench/seg_checker.sv
// checker for the segment intersection block: predicts each result and compares it
`timescale 1ns / 100ps
module seg_checker import segint_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     busy,
  input  seg_in_t  item_i,
  input  logic     strobe_o,
  input  seg_out_t result_o,
  output int       fail_count,
  output int       pending,
  output int       n_none,
  output int       n_point,
  output int       n_coll
);
  localparam int CW = COORD_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam longint OMAX = 64'sd8388607;
  localparam longint OMIN = -64'sd8388608;
  localparam longint QLIM = 64'sd1073741824;

  seg_out_t expected_q[$];

  function automatic longint sx(logic [IN_WIDTH-1:0] v);
    logic [CW-1:0] t;
    t = v[CW-1:0];
    return longint'($signed(t));
  endfunction

  function automatic longint clip24(longint v);
    if (v > OMAX) return OMAX;
    if (v < OMIN) return OMIN;
    return v;
  endfunction

  function automatic longint fixed_quot(longint num, longint den);
    longint q, r, f;
    q = num / den;
    r = num % den;
    f = (r * (64'sd1 <<< FB)) / den;
    if (q > QLIM) q = QLIM;
    if (q < -QLIM) q = -QLIM;
    return clip24(q * (64'sd1 <<< FB) + f);
  endfunction

  function automatic bit meets(longint p, longint q);
    if (p == 0 || q == 0) return 1'b1;
    return (p < 0) != (q < 0);
  endfunction

  function automatic seg_out_t predict_item(seg_in_t it);
    longint x1, y1, x2, y2, x3, y3, x4, y4;
    longint a1, b1, c1, a2, b2, c2, det;
    seg_out_t r;
    x1 = sx(it.ax); y1 = sx(it.ay); x2 = sx(it.bx); y2 = sx(it.by_coord);
    x3 = sx(it.cx); y3 = sx(it.cy); x4 = sx(it.dx); y4 = sx(it.dy);
    r = '0;
    r.outcome = OUT_NONE;
    a1 = y2 - y1; b1 = x1 - x2; c1 = x2 * y1 - x1 * y2;
    if (!meets(a1 * x3 + b1 * y3 + c1, a1 * x4 + b1 * y4 + c1)) return r;
    a2 = y4 - y3; b2 = x3 - x4; c2 = x4 * y3 - x3 * y4;
    if (!meets(a2 * x1 + b2 * y1 + c2, a2 * x2 + b2 * y2 + c2)) return r;
    det = a1 * b2 - a2 * b1;
    if (det == 0) begin
      r.outcome = OUT_COLLINEAR;
      r.point_x = OUT_WIDTH'(clip24(((x1 + x2) * (64'sd1 <<< FB)) / 2));
      r.point_y = OUT_WIDTH'(clip24(((y1 + y2) * (64'sd1 <<< FB)) / 2));
    end else begin
      r.outcome = OUT_POINT;
      r.point_x = OUT_WIDTH'(fixed_quot(b1 * c2 - b2 * c1, det));
      r.point_y = OUT_WIDTH'(fixed_quot(a2 * c1 - a1 * c2, det));
    end
    return r;
  endfunction

  initial begin
    fail_count = 0; pending = 0; n_none = 0; n_point = 0; n_coll = 0;
  end

  always @(posedge clk_i) begin
    seg_out_t e;
    if (rst_ni) begin
      if (strobe_o) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: %p", result_o);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          case (e.outcome)
            OUT_NONE:  n_none++;
            OUT_POINT: n_point++;
            default:   n_coll++;
          endcase
          if (result_o.outcome !== e.outcome) begin
            $error("outcome expected %0d actual %0d", e.outcome, result_o.outcome);
            fail_count++;
          end
          if (result_o.point_x !== e.point_x) begin
            $error("point_x expected %0d actual %0d", e.point_x, result_o.point_x);
            fail_count++;
          end
          if (result_o.point_y !== e.point_y) begin
            $error("point_y expected %0d actual %0d", e.point_y, result_o.point_y);
            fail_count++;
          end
        end
      end
      if (start && !busy) expected_q.push_back(predict_item(item_i));
      pending = expected_q.size();
    end
  end
endmodule

FILE: bench/tb_top.sv
// top of the segment intersection testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb_top;
  import segint_pkg::*;

  localparam int N_RANDOM = 1650;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  seg_in_t  item_i = '0;
  logic     strobe_o;
  seg_out_t result_o;
  int       fail_count, pending, n_none, n_point, n_coll;

  seg_in_t  directed_q[$];
  int       sent;
  int       idle_pct;
  int       waited;

  always #5 clk_i = ~clk_i;

  segment_intersection uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .strobe_o(strobe_o), .result_o(result_o)
  );

  seg_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .strobe_o(strobe_o), .result_o(result_o), .fail_count(fail_count),
    .pending(pending), .n_none(n_none), .n_point(n_point), .n_coll(n_coll)
  );

  function automatic seg_in_t mk(int ax, int ay, int bx, int by, int cx, int cy,
                                 int dx, int dy);
    seg_in_t s;
    s.ax = IN_WIDTH'(ax); s.ay = IN_WIDTH'(ay);
    s.bx = IN_WIDTH'(bx); s.by_coord = IN_WIDTH'(by);
    s.cx = IN_WIDTH'(cx); s.cy = IN_WIDTH'(cy);
    s.dx = IN_WIDTH'(dx); s.dy = IN_WIDTH'(dy);
    return s;
  endfunction

  function automatic int rc(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  function automatic seg_in_t random_pair();
    seg_in_t s;
    int k, sp, ox, oy, vx, vy, t0, t1, t2, t3;
    k = $urandom_range(9);
    if (k < 3) begin
      s = seg_in_t'({$urandom, $urandom, $urandom, $urandom});
    end else if (k < 6) begin
      // crossing by construction: other segment through the middle
      sp = (k == 3) ? 4 : (k == 4) ? 300 : 16000;
      s = mk(rc(sp), rc(sp), rc(sp), rc(sp), 0, 0, 0, 0);
      ox = (int'(s.ax) + int'(s.bx)) / 2; oy = (int'(s.ay) + int'(s.by_coord)) / 2;
      vx = rc(sp); vy = rc(sp);
      s.cx = IN_WIDTH'(ox - vx); s.cy = IN_WIDTH'(oy - vy);
      s.dx = IN_WIDTH'(ox + vx); s.dy = IN_WIDTH'(oy + vy);
    end else if (k < 8) begin
      // all four points on one line, overlapping or not
      sp = (k == 6) ? 3 : 200;
      ox = rc(sp * 20); oy = rc(sp * 20); vx = rc(sp); vy = rc(sp);
      t0 = rc(20); t1 = rc(20); t2 = rc(20); t3 = rc(20);
      s = mk(ox + t0 * vx, oy + t0 * vy, ox + t1 * vx, oy + t1 * vy,
             ox + t2 * vx, oy + t2 * vy, ox + t3 * vx, oy + t3 * vy);
    end else begin
      s = mk(rc(3), rc(3), rc(3), rc(3), rc(3), rc(3), rc(3), rc(3));
    end
    return s;
  endfunction

  initial begin
    directed_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    directed_q.push_back(mk(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
    directed_q.push_back(mk(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
    directed_q.push_back(mk(-32768, 0, 32767, 0, 1, -32768, 1, 32767));
    directed_q.push_back(mk(0, 0, 10, 0, 0, 1, 10, 1));
    directed_q.push_back(mk(0, 0, 10, 10, 5, 5, 20, 20));
    directed_q.push_back(mk(0, 0, 10, 10, 11, 11, 20, 20));
    directed_q.push_back(mk(-32768, -32768, 32767, 32767, -5, -5, 7, 7));
    directed_q.push_back(mk(0, 0, 10, 0, 10, 0, 10, 7));
    directed_q.push_back(mk(0, 0, 10, 0, 5, 0, 5, 9));
    directed_q.push_back(mk(3, 3, 3, 3, 0, 0, 6, 6));
    directed_q.push_back(mk(3, 3, 3, 3, 0, 0, 6, 7));
    directed_q.push_back(mk(0, 0, 6, 6, 3, 3, 3, 3));
    directed_q.push_back(mk(0, 0, 3, 1, 0, 1, 1, -2));
    directed_q.push_back(mk(0, 0, 3, 1, 0, 1, 1, 2));
    directed_q.push_back(mk(-1, -1, 1, 1, -1, 1, 1, -1));
    directed_q.push_back(mk(0, 0, -7, 3, 0, 3, -7, 0));
    directed_q.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sent = 0;
    while (sent < directed_q.size() + N_RANDOM) begin
      // phases: no idle, 49 percent idle, no idle, 27 percent idle
      case ((sent * 4) / (directed_q.size() + N_RANDOM))
        1:       idle_pct = 49;
        3:       idle_pct = 27;
        default: idle_pct = 0;
      endcase
      if (start && !busy) sent++;
      if (!start || !busy) begin
        if (sent >= directed_q.size() + N_RANDOM || $urandom_range(99) < idle_pct) begin
          start <= 1'b0;
          item_i <= seg_in_t'({$urandom, $urandom, $urandom, $urandom});
        end else begin
          start <= 1'b1;
          item_i <= (sent < directed_q.size()) ? directed_q[sent] : random_pair();
        end
      end
      @(posedge clk_i);
    end
    start <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 500) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (40) @(posedge clk_i);
    $display("covered %0d segment pairs: %0d apart, %0d crossing, %0d collinear",
             sent, n_none, n_point, n_coll);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("tb_top NOT OK");
    $finish;
  end
endmodule
